>>> hdl/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
// Needs a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define MCRQ_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define MCRQ_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/mcrq_pkg.sv
// Shared types, codes and constants of the multi-CPU ready queue scheduler.
// No dependencies; the front end, back end and top level import it.
`default_nettype none

package mcrq_pkg;

  // Field widths fixed by the interface
  localparam int unsigned CMD_W      = 3;
  localparam int unsigned CPU_W      = 4;
  localparam int unsigned PID_W      = 8;
  localparam int unsigned PRIO_W     = 4;
  localparam int unsigned ACT_W      = 2;
  localparam int unsigned SLICE_W    = 10;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CPUS_W     = 5;
  localparam int unsigned REG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;

  // Default sizes
  localparam int unsigned QUEUE_DEPTH = 256;
  localparam int unsigned MAX_CPUS    = 16;

  // Configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_MODE  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SLICE = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_CPUS  = 2'd2;

  // Scheduling mode that enables wake preemption
  localparam logic [MODE_W-1:0] MODE_PRIO = 2'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_IDLE    = 3'd0,
    CMD_PREEMPT = 3'd1,
    CMD_YIELD   = 3'd2,
    CMD_TERM    = 3'd3,
    CMD_WAKE    = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    OPK_SCHED,
    OPK_PREEMPT,
    OPK_WAKE
  } op_kind_e;

  typedef enum logic [ACT_W-1:0] {
    ACT_DISPATCH = 2'd0,
    ACT_RUN_IDLE = 2'd1,
    ACT_PREEMPT  = 2'd2,
    ACT_DROP     = 2'd3
  } act_e;

  // Classified event handed from the front end to the back end
  typedef struct packed {
    op_kind_e            kind;
    logic [CPU_W-1:0]    cpu;
    logic [PID_W-1:0]    pid;
    logic [PRIO_W-1:0]   prio;
  } op_t;

  // Result item
  typedef struct packed {
    act_e                action;
    logic [CPU_W-1:0]    target_cpu;
    logic [PID_W-1:0]    run_pid;
    logic [SLICE_W-1:0]  slice;
  } res_t;

endpackage

`default_nettype wire

>>> hdl/mcrq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mcrq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> hdl/mcrq_fifo.sv
// Two-entry queue used between the scheduler stages and at the result side.
// Uses assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module mcrq_fifo #(
  parameter int unsigned Width = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output      logic             full_o,
  input  wire logic             pop_i,
  output      logic [Width-1:0] data_o,
  output      logic             empty_o
);

  logic [Width-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `MCRQ_ASSERT(a_no_overflow, !(push_i && full_o), "push into a full queue")
  `MCRQ_ASSERT(a_no_underflow, !(pop_i && empty_o), "pop from an empty queue")
  `MCRQ_ASSERT(a_ptrs_agree, (cnt_q == 2'd1) == (wr_ptr_q != rd_ptr_q), "pointer mismatch")

endmodule

`default_nettype wire

>>> hdl/mcrq_front.sv
// Front end: accepts events, drops unknown commands and (but for wakes) out-of-range CPUs,
// classifies the rest and queues them for the back end. Uses mcrq_pkg, mcrq_fifo.
`default_nettype none

module mcrq_front #(
  parameter int unsigned MaxCpus = mcrq_pkg::MAX_CPUS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push_i,
  output      logic                          full_o,
  input  wire logic [mcrq_pkg::CMD_W-1:0]    cmd_i,
  input  wire logic [mcrq_pkg::CPU_W-1:0]    cpu_i,
  input  wire logic [mcrq_pkg::PID_W-1:0]    pid_i,
  input  wire logic [mcrq_pkg::PRIO_W-1:0]   priority_req_i,
  input  wire logic [((($clog2(MaxCpus+1)) > mcrq_pkg::CPUS_W) ?
                      $clog2(MaxCpus+1) : mcrq_pkg::CPUS_W)-1:0] cpu_limit_i,
  input  wire logic                          op_pop_i,
  output      mcrq_pkg::op_t                 op_o,
  output      logic                          op_empty_o
);

  import mcrq_pkg::*;

  localparam int unsigned LimW = ($clog2(MaxCpus+1) > CPUS_W) ? $clog2(MaxCpus+1) : CPUS_W;

  op_t  op;
  logic op_valid;
  logic in_range;
  logic accept;

  assign accept   = push_i & ~full_o;
  assign in_range = (LimW'(cpu_i) < cpu_limit_i);

  // Classify the event
  always_comb begin
    op.cpu   = cpu_i;
    op.pid   = pid_i;
    op.prio  = priority_req_i;
    op.kind  = OPK_SCHED;
    op_valid = 1'b0;
    unique case (cmd_e'(cmd_i)) inside
      CMD_IDLE, CMD_YIELD, CMD_TERM: begin
        op.kind  = OPK_SCHED;
        op_valid = in_range;
      end
      CMD_PREEMPT: begin
        op.kind  = OPK_PREEMPT;
        op_valid = in_range;
      end
      CMD_WAKE: begin
        op.kind  = OPK_WAKE;
        op_valid = 1'b1;
      end
      default: begin
        op_valid = 1'b0;
      end
    endcase
  end

  mcrq_fifo #(
    .Width($bits(op_t))
  ) u_op_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept & op_valid),
    .data_i (op),
    .full_o (full_o),
    .pop_i  (op_pop_i),
    .data_o (op_o),
    .empty_o(op_empty_o)
  );

endmodule

`default_nettype wire

>>> hdl/mcrq_back.sv
// Back end: ready queue, CPU table and the sequencer that carries out events.
// Uses mcrq_pkg, mcrq_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module mcrq_back #(
  parameter int unsigned QueueDepth = mcrq_pkg::QUEUE_DEPTH,
  parameter int unsigned MaxCpus    = mcrq_pkg::MAX_CPUS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          op_empty_i,
  input  wire mcrq_pkg::op_t                 op_i,
  output      logic                          op_pop_o,
  input  wire logic                          out_full_i,
  output      logic                          res_push_o,
  output      mcrq_pkg::res_t                res_o,
  input  wire logic [mcrq_pkg::MODE_W-1:0]   sched_mode_i,
  input  wire logic [mcrq_pkg::SLICE_W-1:0]  time_slice_i,
  input  wire logic [((($clog2(MaxCpus+1)) > mcrq_pkg::CPUS_W) ?
                      $clog2(MaxCpus+1) : mcrq_pkg::CPUS_W)-1:0] cpu_limit_i
);

  import mcrq_pkg::*;

  localparam int unsigned AddrW   = $clog2(QueueDepth);
  localparam int unsigned CntW    = $clog2(QueueDepth + 1);
  localparam int unsigned CpuIdxW = (MaxCpus > 1) ? $clog2(MaxCpus) : 1;
  localparam int unsigned LimW    = ($clog2(MaxCpus+1) > CPUS_W) ? $clog2(MaxCpus+1) : CPUS_W;
  localparam int unsigned EntW    = PID_W + PRIO_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_READ,
    S_DISP,
    S_SCAN
  } state_e;

  state_e               state_q, state_d;
  op_t                  op_q, op_d;
  logic [AddrW-1:0]     head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [MaxCpus-1:0]   busy_q, busy_d;
  logic [PID_W-1:0]     cpu_pid_q  [MaxCpus];
  logic [PRIO_W-1:0]    cpu_prio_q [MaxCpus];
  logic [LimW-1:0]      scan_q, scan_d;
  logic [CpuIdxW-1:0]   best_q, best_d;
  logic [PRIO_W-1:0]    best_prio_q, best_prio_d;

  logic [CpuIdxW-1:0]   rd_idx, op_idx, cand_idx;
  logic                 rd_busy, take, q_full, q_empty;
  logic [PID_W-1:0]     rd_pid;
  logic [PRIO_W-1:0]    rd_prio, cand_prio;
  logic                 tbl_we;
  logic                 ram_we, ram_re;
  logic [EntW-1:0]      ram_wdata, ram_rdata;
  logic [AddrW-1:0]     head_nxt, tail_nxt;

  assign op_idx   = CpuIdxW'(op_q.cpu);
  assign rd_idx   = (state_q == S_SCAN) ? scan_q[CpuIdxW-1:0] : op_idx;
  assign rd_busy  = busy_q[rd_idx];
  assign rd_pid   = cpu_pid_q[rd_idx];
  assign rd_prio  = cpu_prio_q[rd_idx];
  assign q_full   = (count_q == CntW'(QueueDepth));
  assign q_empty  = (count_q == '0);
  assign head_nxt = (head_q == AddrW'(QueueDepth - 1)) ? '0 : head_q + AddrW'(1);
  assign tail_nxt = (tail_q == AddrW'(QueueDepth - 1)) ? '0 : tail_q + AddrW'(1);

  // Running minimum of the scan, lowest index wins ties
  assign take      = (scan_q == '0) || (rd_prio < best_prio_q);
  assign cand_idx  = take ? rd_idx : best_q;
  assign cand_prio = take ? rd_prio : best_prio_q;

  // Sequence one event at a time
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    busy_d      = busy_q;
    scan_d      = scan_q;
    best_d      = best_q;
    best_prio_d = best_prio_q;
    op_pop_o    = 1'b0;
    res_push_o  = 1'b0;
    res_o.action     = ACT_DISPATCH;
    res_o.target_cpu = op_q.cpu;
    res_o.run_pid    = '0;
    res_o.slice      = '0;
    ram_we      = 1'b0;
    ram_wdata   = {op_q.pid, op_q.prio};
    ram_re      = 1'b0;
    tbl_we      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        // Take the next event only while a result slot is free
        if (!op_empty_i && !out_full_i) begin
          op_pop_o = 1'b1;
          op_d     = op_i;
          state_d  = S_START;
        end
      end

      S_START: begin
        state_d = S_IDLE;
        if (op_q.kind == OPK_WAKE) begin
          if (q_full) begin
            res_push_o       = 1'b1;
            res_o.action     = ACT_DROP;
            res_o.target_cpu = '0;
          end else begin
            ram_we    = 1'b1;
            ram_wdata = {op_q.pid, op_q.prio};
            tail_d    = tail_nxt;
            count_d   = count_q + CntW'(1);
            if (sched_mode_i == MODE_PRIO) begin
              scan_d  = '0;
              state_d = S_SCAN;
            end
          end
        end else if (op_q.kind == OPK_PREEMPT && rd_busy && q_full) begin
          // Requeue does not fit: CPU keeps its process
          res_push_o   = 1'b1;
          res_o.action = ACT_DROP;
        end else begin
          if (op_q.kind == OPK_PREEMPT && rd_busy) begin
            // Requeue the running process, then dispatch the head
            ram_we    = 1'b1;
            ram_wdata = {rd_pid, rd_prio};
            tail_d    = tail_nxt;
            count_d   = count_q + CntW'(1);
            state_d   = S_READ;
          end else if (q_empty) begin
            busy_d[op_idx] = 1'b0;
            res_push_o     = 1'b1;
            res_o.action   = ACT_RUN_IDLE;
            res_o.slice    = time_slice_i;
          end else begin
            state_d = S_READ;
          end
        end
      end

      S_READ: begin
        ram_re  = 1'b1;
        state_d = S_DISP;
      end

      S_DISP: begin
        tbl_we         = 1'b1;
        busy_d[op_idx] = 1'b1;
        head_d         = head_nxt;
        count_d        = count_q - CntW'(1);
        res_push_o     = 1'b1;
        res_o.action   = ACT_DISPATCH;
        res_o.run_pid  = ram_rdata[EntW-1:PRIO_W];
        res_o.slice    = time_slice_i;
        state_d        = S_IDLE;
      end

      S_SCAN: begin
        if (!rd_busy) begin
          // An idle CPU will pick the process up
          state_d = S_IDLE;
        end else begin
          best_d      = cand_idx;
          best_prio_d = cand_prio;
          scan_d      = scan_q + LimW'(1);
          if (scan_q == cpu_limit_i - LimW'(1)) begin
            state_d = S_IDLE;
            if (cand_prio <= op_q.prio) begin
              res_push_o       = 1'b1;
              res_o.action     = ACT_PREEMPT;
              res_o.target_cpu = CPU_W'(cand_idx);
            end
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      busy_q  <= '0;
      scan_q  <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      busy_q  <= busy_d;
      scan_q  <= scan_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    best_q      <= best_d;
    best_prio_q <= best_prio_d;
    if (tbl_we) begin
      cpu_pid_q[op_idx]  <= ram_rdata[EntW-1:PRIO_W];
      cpu_prio_q[op_idx] <= ram_rdata[PRIO_W-1:0];
    end
  end

  mcrq_ram #(
    .Width(EntW),
    .Depth(QueueDepth)
  ) u_ready_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(tail_q),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(head_q),
    .rdata_o(ram_rdata)
  );

  `MCRQ_ASSERT(a_count_bound, count_q <= CntW'(QueueDepth), "ready queue count overrun")
  `MCRQ_ASSERT(a_ptr_match, (count_q != '0 && !q_full) || head_q == tail_q, "queue pointers drift")
  `MCRQ_ASSERT(a_result_room, !(res_push_o && out_full_i), "result with no free slot")
  `MCRQ_ASSERT(a_disp_nonempty, state_q != S_DISP || count_q != '0, "dispatch from empty queue")
  `MCRQ_ASSERT_NEXT(a_read_then_disp, state_q == S_READ, state_q == S_DISP, "read not followed by dispatch")

endmodule

`default_nettype wire

>>> hdl/multi_cpu_ready_queue_scheduler.sv
// Ready queue scheduler for several CPUs: FIFO ready queue plus per-CPU table.
// Back-end states: IDLE, START for run idle, a drop or no result; IDLE, START, READ, DISP for
// a dispatch. A wake in priority mode adds SCAN over up to the clamped CPU count of entries.
// A result is written to the result queue in its last state and shows on the output ports once
// earlier results are popped; the CPU table read port sets the scan rate.
// Reset (async, active low) empties all queues, marks every CPU idle and loads register defaults.
`default_nettype none

module multi_cpu_ready_queue_scheduler #(
  parameter int unsigned QueueDepth = mcrq_pkg::QUEUE_DEPTH,
  parameter int unsigned MaxCpus    = mcrq_pkg::MAX_CPUS
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Event input
  input  wire logic                              push,
  output      logic                              full,
  input  wire logic [mcrq_pkg::CMD_W-1:0]        cmd_i,
  input  wire logic [mcrq_pkg::CPU_W-1:0]        cpu_i,
  input  wire logic [mcrq_pkg::PID_W-1:0]        pid_i,
  input  wire logic [mcrq_pkg::PRIO_W-1:0]       priority_req_i,
  // Result output
  output      logic                              empty,
  input  wire logic                              pop,
  output      logic [mcrq_pkg::ACT_W-1:0]        action_o,
  output      logic [mcrq_pkg::CPU_W-1:0]        target_cpu_o,
  output      logic [mcrq_pkg::PID_W-1:0]        run_pid_o,
  output      logic [mcrq_pkg::SLICE_W-1:0]      slice_o,
  // Configuration writes
  input  wire logic                              cfg_valid_i,
  output      logic                              cfg_ready_o,
  input  wire logic [mcrq_pkg::REG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [mcrq_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  import mcrq_pkg::*;

  localparam int unsigned LimW = ($clog2(MaxCpus+1) > CPUS_W) ? $clog2(MaxCpus+1) : CPUS_W;

  logic [MODE_W-1:0]  mode_q;
  logic [SLICE_W-1:0] slice_q;
  logic [CPUS_W-1:0]  cpus_q;
  logic [LimW-1:0]    cpus_ext, cpu_limit;

  op_t  op;
  logic op_empty, op_pop;
  res_t res_in, res_out;
  logic res_push, res_full;

  assign cfg_ready_o = 1'b1;

  // Load configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= '0;
      slice_q <= '0;
      cpus_q  <= CPUS_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_MODE:  mode_q  <= cfg_data_i[MODE_W-1:0];
        REG_SLICE: slice_q <= cfg_data_i[SLICE_W-1:0];
        REG_CPUS:  cpus_q  <= cfg_data_i[CPUS_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the CPU count to 1..MaxCpus
  assign cpus_ext  = LimW'(cpus_q);
  assign cpu_limit = (cpus_ext == '0) ? LimW'(1) :
                     (cpus_ext > LimW'(MaxCpus)) ? LimW'(MaxCpus) : cpus_ext;

  mcrq_front #(
    .MaxCpus(MaxCpus)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .cmd_i         (cmd_i),
    .cpu_i         (cpu_i),
    .pid_i         (pid_i),
    .priority_req_i(priority_req_i),
    .cpu_limit_i   (cpu_limit),
    .op_pop_i      (op_pop),
    .op_o          (op),
    .op_empty_o    (op_empty)
  );

  mcrq_back #(
    .QueueDepth(QueueDepth),
    .MaxCpus   (MaxCpus)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_empty_i  (op_empty),
    .op_i        (op),
    .op_pop_o    (op_pop),
    .out_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .sched_mode_i(mode_q),
    .time_slice_i(slice_q),
    .cpu_limit_i (cpu_limit)
  );

  mcrq_fifo #(
    .Width($bits(res_t))
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .full_o (res_full),
    .pop_i  (pop & ~empty),
    .data_o (res_out),
    .empty_o(empty)
  );

  assign action_o     = res_out.action;
  assign target_cpu_o = res_out.target_cpu;
  assign run_pid_o    = res_out.run_pid;
  assign slice_o      = res_out.slice;

endmodule

`default_nettype wire
